>>> hdl/quaternion_to_euler_top_macros.svh
// assertion macros for the quaternion to euler block
`ifndef QUATERNION_TO_EULER_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define Q2E_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("q2e check failed");
// implication checked in the cycle after the antecedent
`define Q2E_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("q2e check failed");
`endif

>>> hdl/q2e_pkg.sv
// shared constants, types and tables for the quaternion to euler block
package q2e_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUAT_FRAC_BITS_DEF = 14;
	// cordic datapath width: q products up to 2^60 plus growth
	localparam int DW = 66;
	localparam int AW = 34;
	localparam logic signed [AW-1:0] ANG_PI = 34'sd3373259426;
	localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd1686629713;
	localparam logic signed [14:0] PITCH_MAX = 15'sd12868;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [AW-1:0] z;
		logic zero;
	} cord_t;

	typedef struct packed {
		logic clamp;
		logic neg;
	} pflag_t;

	function automatic logic signed [AW-1:0] atan_q30(input int i);
		logic signed [AW-1:0] r;
		begin
			unique case (i)
				0: r = 34'sd843314857;
				1: r = 34'sd497837829;
				2: r = 34'sd263043837;
				3: r = 34'sd133525159;
				4: r = 34'sd67021687;
				5: r = 34'sd33543516;
				6: r = 34'sd16775851;
				7: r = 34'sd8388437;
				8: r = 34'sd4194283;
				9: r = 34'sd2097149;
				default: r = (i < 31) ? (AW'(1) <<< (30 - i)) : '0;
			endcase
			return r;
		end
	endfunction

	// saturate to +-lim and round half up to q2.13
	function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] z,
			input logic signed [AW-1:0] lim);
		logic signed [AW-1:0] s;
		logic signed [AW-1:0] r;
		begin
			s = z;
			if (s > lim) s = lim;
			if (s < -lim) s = -lim;
			r = (s + (AW'(1) <<< 16)) >>> 17;
			return r[15:0];
		end
	endfunction
endpackage

>>> hdl/q2e_cell.sv
// one cordic micro-rotation cell with a register
module q2e_cell #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input logic vin,
	input q2e_pkg::cord_t din,
	output logic vout,
	output q2e_pkg::cord_t dout
);
	import q2e_pkg::*;
	cord_t nxt;

	// rotate toward y = 0
	always_comb begin
		nxt = din;
		if (din.y >= 0) begin
			nxt.x = din.x + (din.y >>> STEP);
			nxt.y = din.y - (din.x >>> STEP);
			nxt.z = din.z + atan_q30(STEP);
		end else begin
			nxt.x = din.x - (din.y >>> STEP);
			nxt.y = din.y + (din.x >>> STEP);
			nxt.z = din.z - atan_q30(STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule

>>> hdl/q2e_chain.sv
// row of cordic cells with quadrant pre-rotation, gives atan2 in q2.30
module q2e_chain #(
	parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic vin,
	input logic signed [q2e_pkg::DW-1:0] yin,
	input logic signed [q2e_pkg::DW-1:0] xin,
	output logic vout,
	output logic signed [q2e_pkg::AW-1:0] ang
);
	import q2e_pkg::*;
	localparam int N = (STEPS > 32) ? 32 : STEPS;
	cord_t c [0:N];
	logic v [0:N];

	// quadrant pre-rotation
	always_comb begin
		c[0].zero = (xin == '0) && (yin == '0);
		c[0].x = xin;
		c[0].y = yin;
		c[0].z = '0;
		if (xin < 0) begin
			if (yin >= 0) begin
				c[0].x = yin;
				c[0].y = -xin;
				c[0].z = ANG_HALF_PI;
			end else begin
				c[0].x = -yin;
				c[0].y = xin;
				c[0].z = -ANG_HALF_PI;
			end
		end
		v[0] = vin;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		q2e_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .vin(v[i]), .din(c[i]),
			.vout(v[i+1]), .dout(c[i+1]));
	end

	// zero-input handling and overshoot saturation
	always_comb begin
		vout = v[N];
		if (c[N].zero) ang = '0;
		else if (c[N].z > ANG_PI) ang = ANG_PI;
		else if (c[N].z < -ANG_PI) ang = -ANG_PI;
		else ang = c[N].z;
	end
endmodule

>>> hdl/q2e_sqrt.sv
// pipelined floor square root, one result bit per stage
module q2e_sqrt #(
	parameter int IW = 60
) (
	input logic clk,
	input logic arst_n,
	input logic vin,
	input logic [IW-1:0] din,
	input logic signed [q2e_pkg::DW-1:0] sin,
	input logic [1:0] fin,
	output logic vout,
	output logic [IW/2-1:0] root,
	output logic signed [q2e_pkg::DW-1:0] sout,
	output logic [1:0] fout
);
	import q2e_pkg::*;
	localparam int RW = IW / 2;
	logic [IW-1:0] rem [0:RW];
	logic [RW-1:0] res [0:RW];
	logic [IW-1:0] src [0:RW];
	logic signed [DW-1:0] sp [0:RW];
	logic [1:0] fp [0:RW];
	logic v [0:RW];

	assign rem[0] = '0;
	assign res[0] = '0;
	assign src[0] = din;
	assign sp[0] = sin;
	assign fp[0] = fin;
	assign v[0] = vin;

	for (genvar i = 0; i < RW; i++) begin : g_bit
		logic [IW+1:0] trial;
		logic [IW+1:0] rsh;
		// bring down two bits, try next root bit
		always_comb begin
			rsh = {rem[i], src[i][IW-1 -: 2]};
			trial = {(IW+2-RW-2)'(0), res[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i+1] <= 1'b0;
			end else begin
				v[i+1] <= v[i];
			end
		end
		always_ff @(posedge clk) begin
			src[i+1] <= src[i] << 2;
			sp[i+1] <= sp[i];
			fp[i+1] <= fp[i];
			if (rsh >= trial) begin
				rem[i+1] <= IW'(rsh - trial);
				res[i+1] <= {res[i][RW-2:0], 1'b1};
			end else begin
				rem[i+1] <= IW'(rsh);
				res[i+1] <= {res[i][RW-2:0], 1'b0};
			end
		end
	end

	assign vout = v[RW];
	assign root = res[RW];
	assign sout = sp[RW];
	assign fout = fp[RW];
endmodule

>>> hdl/quaternion_to_euler_top.sv
// quaternion to euler angles (zyx), all stages pipelined
// every result leaves with roll and yaw delayed to match the pitch path
// throughput: one quaternion per cycle, busy is tied low
// the receiver cannot stall: done pulses for one cycle with the angles
// reset clears only valid bits; payload registers are not reset
module quaternion_to_euler_top
	import q2e_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] quat_w,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	output logic done,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic pitch_clamped
);
	localparam int SQ = 30;
	localparam int F2 = 2 * QUAT_FRAC_BITS;
	localparam logic signed [DW-1:0] P_ONE = DW'(1) <<< F2;
	logic signed [33:0] pw_s1 [0:9];
	logic v_s1, v_s2;
	logic signed [DW-1:0] ra_s2, rb_s2, ya_s2, yb_s2, q_s2;
	logic [59:0] rad_s2;
	pflag_t pf_s2;
	logic signed [DW-1:0] p_c, q_c;
	logic signed [30:0] qn_c;
	logic v_sq, v_p, v_r, v_y;
	logic [29:0] root;
	logic signed [DW-1:0] q_sq;
	logic [1:0] f_sq;
	logic signed [AW-1:0] ang_p, ang_r, ang_y;
	logic signed [AW-1:0] rd [0:SQ];
	logic signed [AW-1:0] yd [0:SQ];
	logic [1:0] fd [0:CORDIC_STEPS];

	assign busy = 1'b0;

	// products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		pw_s1[0] <= 34'(quat_w * quat_w);
		pw_s1[1] <= 34'(quat_x * quat_x);
		pw_s1[2] <= 34'(quat_y * quat_y);
		pw_s1[3] <= 34'(quat_z * quat_z);
		pw_s1[4] <= 34'(quat_y * quat_z);
		pw_s1[5] <= 34'(quat_w * quat_x);
		pw_s1[6] <= 34'(quat_x * quat_y);
		pw_s1[7] <= 34'(quat_w * quat_z);
		pw_s1[8] <= 34'(quat_w * quat_y);
		pw_s1[9] <= 34'(quat_x * quat_z);
	end

	// matrix terms and scaled pitch argument
	always_comb begin
		p_c = DW'(pw_s1[8] - pw_s1[9]) <<< 1;
		if (F2 >= 30) q_c = p_c >>> (F2 - 30);
		else q_c = p_c <<< (30 - F2);
		// below the clamp the scaled argument fits in 31 bits
		qn_c = q_c[30:0];
	end
	always_ff @(posedge clk) begin
		ra_s2 <= DW'(pw_s1[4] + pw_s1[5]) <<< 1;
		rb_s2 <= DW'(pw_s1[0] - pw_s1[1] - pw_s1[2] + pw_s1[3]);
		ya_s2 <= DW'(pw_s1[6] + pw_s1[7]) <<< 1;
		yb_s2 <= DW'(pw_s1[0] + pw_s1[1] - pw_s1[2] - pw_s1[3]);
		q_s2 <= q_c;
		pf_s2.clamp <= (p_c >= P_ONE) || (p_c <= -P_ONE);
		pf_s2.neg <= p_c < 0;
		rad_s2 <= 60'((61'(1) <<< 60) - 61'(qn_c * qn_c));
	end

	q2e_sqrt #(.IW(60)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .vin(v_s2), .din(rad_s2), .sin(q_s2),
		.fin({pf_s2.clamp, pf_s2.neg}), .vout(v_sq), .root(root), .sout(q_sq),
		.fout(f_sq));

	q2e_chain #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .arst_n(arst_n), .vin(v_sq), .yin(q_sq),
		.xin(DW'({1'b0, root})), .vout(v_p), .ang(ang_p));
	q2e_chain #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .arst_n(arst_n), .vin(v_s2), .yin(ra_s2), .xin(rb_s2),
		.vout(v_r), .ang(ang_r));
	q2e_chain #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .arst_n(arst_n), .vin(v_s2), .yin(ya_s2), .xin(yb_s2),
		.vout(v_y), .ang(ang_y));

	// delay roll and yaw by the square root depth
	assign rd[0] = ang_r;
	assign yd[0] = ang_y;
	for (genvar i = 0; i < SQ; i++) begin : g_dly
		always_ff @(posedge clk) begin
			rd[i+1] <= rd[i];
			yd[i+1] <= yd[i];
		end
	end
	// carry clamp flags alongside the pitch chain
	assign fd[0] = f_sq;
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_fd
		always_ff @(posedge clk) fd[i+1] <= fd[i];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_p;
		end
	end
	always_ff @(posedge clk) begin
		roll_angle <= to_q13(rd[SQ], ANG_PI);
		yaw_angle <= to_q13(yd[SQ], ANG_PI);
		pitch_clamped <= fd[CORDIC_STEPS][1];
		if (fd[CORDIC_STEPS][1]) begin
			pitch_angle <= fd[CORDIC_STEPS][0] ? -PITCH_MAX : PITCH_MAX;
		end else begin
			pitch_angle <= 15'(to_q13(ang_p, ANG_HALF_PI));
		end
	end
endmodule

>>> hdl/q2e_checker.sv
// port checker for the quaternion to euler block, with its bind
module q2e_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [14:0] pitch_angle,
	input logic signed [15:0] roll_angle,
	input logic pitch_clamped
);
`include "quaternion_to_euler_top_macros.svh"
	`Q2E_ASSERT_IMP(a_clamp_val, done && pitch_clamped, pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868)
	`Q2E_ASSERT_IMP(a_pitch_rng, done, pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)
	`Q2E_ASSERT_IMP(a_roll_rng, done, roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736)
	`Q2E_ASSERT_NEXT(a_no_busy, 1'b1, !busy)
endmodule

bind quaternion_to_euler_top q2e_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pitch_angle(pitch_angle), .roll_angle(roll_angle), .pitch_clamped(pitch_clamped));

>>> tb/quaternion_to_euler_top_tb.sv
// self-checking testbench for the quaternion to euler angle block
`timescale 1ns / 1ps
module quaternion_to_euler_top_tb;
	import q2e_pkg::*;

	localparam int STEPS = 16;
	localparam int FRAC = 14;
	localparam int DRAIN = 2 + 30 + STEPS + 1 + 10;
	localparam int IDLE_LIMIT = 5000;
	localparam int N_RANDOM = 1250;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam logic signed [14:0] PITCH_LIM = 15'sd12868;

	localparam longint ARCTAN_Q30 [32] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1, 0
	};

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic clamp;
	} euler_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic done;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic pitch_clamped;

	int beats_in;
	int idle_cycles;

	// expected angles and the comparison against the block
	class angle_board;
		euler_t pending[$];
		int errors;

		function longint arctan2(longint yv, longint xv);
			longint ang, t, nx, ny;
			ang = 0;
			if (xv == 0 && yv == 0) return 0;
			if (xv < 0) begin
				if (yv >= 0) begin
					t = xv; xv = yv; yv = -t; ang = HALF_PI_Q30;
				end else begin
					t = xv; xv = -yv; yv = t; ang = -HALF_PI_Q30;
				end
			end
			for (int i = 0; i < STEPS && i < 32; i++) begin
				if (yv >= 0) begin
					nx = xv + (yv >>> i);
					ny = yv - (xv >>> i);
					ang += ARCTAN_Q30[i];
				end else begin
					nx = xv - (yv >>> i);
					ny = yv + (xv >>> i);
					ang -= ARCTAN_Q30[i];
				end
				xv = nx;
				yv = ny;
			end
			if (ang > PI_Q30) ang = PI_Q30;
			if (ang < -PI_Q30) ang = -PI_Q30;
			return ang;
		endfunction

		function longint unsigned int_root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint to_q13(longint a);
			return (a + (64'sd1 << 16)) >>> 17;
		endfunction

		function void note(longint w, longint x, longint y, longint z);
			euler_t e;
			longint ra, rb, ya, yb, p, q, ang, one, r, yw, pt;
			longint unsigned c;
			ra = 2 * (y * z + w * x);
			rb = w * w - x * x - y * y + z * z;
			ya = 2 * (x * y + w * z);
			yb = w * w + x * x - y * y - z * z;
			p = 2 * (w * y - x * z);
			r = to_q13(arctan2(ra, rb));
			yw = to_q13(arctan2(ya, yb));
			one = 64'sd1 << (2 * FRAC);
			e.clamp = 1'b0;
			if (p >= one) begin
				pt = PITCH_LIM;
				e.clamp = 1'b1;
			end else if (p <= -one) begin
				pt = -PITCH_LIM;
				e.clamp = 1'b1;
			end else begin
				q = p * (64'sd1 << (30 - 2 * FRAC));
				c = int_root(64'(ONE_Q30) * 64'(ONE_Q30) - 64'(q * q));
				ang = arctan2(q, longint'(c));
				if (ang > HALF_PI_Q30) ang = HALF_PI_Q30;
				if (ang < -HALF_PI_Q30) ang = -HALF_PI_Q30;
				pt = to_q13(ang);
			end
			e.roll = r[15:0];
			e.pitch = pt[14:0];
			e.yaw = yw[15:0];
			pending.push_back(e);
		endfunction

		task report(string what, longint got, longint want);
			$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check(logic signed [15:0] r, logic signed [14:0] p, logic signed [15:0] y,
				logic c);
			euler_t e;
			if (pending.size() == 0) begin
				report("unexpected result, roll", r, 0);
				return;
			end
			e = pending.pop_front();
			if (r !== e.roll) report("roll_angle", r, e.roll);
			if (p !== e.pitch) report("pitch_angle", p, e.pitch);
			if (y !== e.yaw) report("yaw_angle", y, e.yaw);
			if (c !== e.clamp) report("pitch_clamped", c, e.clamp);
		endtask
	endclass

	angle_board board;

	quaternion_to_euler_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
	);

	// clock
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// input beats and result beats seen at the rising edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			board.note(quat_w, quat_x, quat_y, quat_z);
			beats_in = beats_in + 1;
		end
		if (arst_n && done)
			board.check(roll_angle, pitch_angle, yaw_angle, pitch_clamped);
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	int burst_left;

	// drive one quaternion and hold it until taken
	task send_quat(logic signed [15:0] w, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		int target;
		if (burst_left == 0) begin
			start = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		target = beats_in + 1;
		quat_w = w; quat_x = x; quat_y = y; quat_z = z;
		start = 1'b1;
		wait (beats_in >= target);
		@(negedge clk);
	endtask

	function logic signed [15:0] unit_comp();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	int pick;

	initial begin
		board = new();
		beats_in = 0;
		idle_cycles = 0;
		burst_left = 0;
		start = 1'b0;
		quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: identity, axes, clamps, zero operands, extremes
		send_quat(16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(16384, 0, 16384, 0);
		send_quat(16384, 0, -16384, 0);
		send_quat(16384, 0, 8192, 0);
		send_quat(16384, 0, -8192, 0);
		send_quat(11585, 0, 11585, 0);
		send_quat(0, 11585, 0, -11585);
		send_quat(11585, 11585, 0, 0);
		send_quat(11585, -11585, 0, 0);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(-8192, 8192, -8192, 8192);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(32767, -32768, 32767, -32768);
		send_quat(-1, -1, -1, -1);
		send_quat(1, 0, 0, -1);
		send_quat(0, -16384, 0, 0);

		// random: mostly components within +-1.0 (some with x and z near zero), some raw bit patterns
		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_quat(unit_comp(), unit_comp(), unit_comp(), unit_comp());
			else if (pick < 8)
				send_quat(unit_comp(), 16'($signed($urandom_range(0, 4)) - 2), unit_comp(),
					16'($signed($urandom_range(0, 4)) - 2));
			else
				send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end
		start = 1'b0;

		// drain
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
